### rtl/core/mf3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants of the 3x3 median filter: pixel, window,
// line-buffer entry and result-tag types, register indexes and reset values.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int WINDOW        = 3;
    localparam int WIN_CELLS     = WINDOW * WINDOW;

    localparam int PIX_W     = 8;
    localparam int CFG_W_W   = 12;
    localparam int CFG_H_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_ROW_W = 16;
    localparam int OUT_COL_W = 11;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Register indexes of the configuration port
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [PIX_W-1:0] pix_t;

    // Row-major 3x3 window, top row first; cell 0 in the lowest bits
    typedef pix_t [WIN_CELLS-1:0] window_t;

    // One line-buffer entry: the pixel two rows back and the one a row back
    typedef struct packed {
        pix_t upper;
        pix_t lower;
    } line_pair_t;

    // Position tag that travels with a result through the sorter
    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } out_meta_t;

endpackage

### rtl/core/mf3_linebuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_linebuf
// Two row buffers kept as one memory of pixel pairs, with registered read
// and a bypass for a read of the column that is written in the same cycle.
// ----------------------------------------------------------------------------
module mf3_linebuf
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int AW = $clog2(MAX_WIDTH)
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  line_pair_t    wr_data,
    output line_pair_t    rd_data
);

    line_pair_t mem [MAX_WIDTH];
    line_pair_t mem_q_reg;
    line_pair_t byp_data_reg;
    logic       byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            // same column written at this edge: take the new pair
            byp_reg      <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : mem_q_reg;

endmodule

### rtl/core/mf3_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf3_median
// Two-stage median-of-nine: sort each window row, then combine the row
// minimums, middles and maximums; result held in the output register.
// ----------------------------------------------------------------------------
module mf3_median
    import mf3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  window_t   win,
    input  out_meta_t in_meta,
    output logic      out_valid,
    input  logic      out_ready,
    output pix_t      out_median,
    output out_meta_t out_meta
);

    typedef struct packed {
        pix_t lo;
        pix_t mid;
        pix_t hi;
    } trio_t;

    function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
        pix_t  x0;
        pix_t  x1;
        pix_t  x2;
        pix_t  t;
        trio_t r;
        x0 = a;
        x1 = b;
        x2 = c;
        if (x0 > x1)
        begin
            t = x0; x0 = x1; x1 = t;
        end
        if (x1 > x2)
        begin
            t = x1; x1 = x2; x2 = t;
        end
        if (x0 > x1)
        begin
            t = x0; x0 = x1; x1 = t;
        end
        r.lo  = x0;
        r.mid = x1;
        r.hi  = x2;
        return r;
    endfunction

    function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
        pix_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
        pix_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        pix_t lo;
        pix_t hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (c < lo) ? lo : ((c > hi) ? hi : c);
    endfunction

    trio_t     rows_reg [WINDOW];
    out_meta_t meta_a_reg;
    logic      va_reg;
    logic      vb_reg;
    pix_t      med_reg;
    out_meta_t meta_b_reg;

    logic rdy_a;
    logic rdy_b;

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                va_reg <= in_valid;
            end
            if (rdy_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            for (int r = 0; r < WINDOW; r++)
            begin
                rows_reg[r] <= sort3(win[r*WINDOW], win[r*WINDOW+1], win[r*WINDOW+2]);
            end
            meta_a_reg <= in_meta;
        end
        if (rdy_b && va_reg)
        begin
            med_reg <= med3(max3(rows_reg[0].lo, rows_reg[1].lo, rows_reg[2].lo),
                            med3(rows_reg[0].mid, rows_reg[1].mid, rows_reg[2].mid),
                            min3(rows_reg[0].hi, rows_reg[1].hi, rows_reg[2].hi));
            meta_b_reg <= meta_a_reg;
        end
    end

    assign out_valid  = vb_reg;
    assign out_median = med_reg;
    assign out_meta   = meta_b_reg;

endmodule

### rtl/core/median_filter_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter for 8-bit grayscale images in raster order.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while m_tready lets results drain; a
// stall there backs up to s_tready. Every stage can take a new request in
// the cycle it hands its last one on, and the one line-buffer memory does
// one read and one write per cycle, which sets the figure of one pixel per
// cycle. Each result passes input register, window, row sort, output register.
// Each pixel at row >= 2 and column >= 2 yields the median of the 3x3
// neighborhood centered one row up and one column left; border pixels yield
// nothing. tuser on the input marks the first pixel of a frame and resets
// the position; without it the position wraps at the end of each frame.
// tlast on the output marks the result of the frame's last pixel. The
// width in use is saturated to 3..MAX_WIDTH and the height to at least 3.
// The line buffers start undefined and need no clearing pass; what they hold
// reaches a result only after two rows are written. Write configuration only
// while the block is idle.
// ----------------------------------------------------------------------------
module median_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration write port
    input  logic                  cfg_wen,
    input  cfg_index_t            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // Pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] pixel
    input  logic                  s_tuser,   // [0] frame_start

    // Filtered output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // [7:0] median_value, [23:8] out_row,
                                             // [34:24] out_col, [39:35] zero
    output logic                  m_tlast    // frame_end
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > CFG_W_W) ?
                            $clog2(MAX_WIDTH + 1) : CFG_W_W;

    // Saturate a width to 3..MAX_WIDTH and return the last column index
    function automatic logic [COL_W-1:0] width_last(input logic [CFG_W_W-1:0] w);
        logic [WCMP_W-1:0] wx;
        wx = WCMP_W'(w);
        if (wx < WCMP_W'(3))
        begin
            wx = WCMP_W'(3);
        end
        else if (wx > WCMP_W'(MAX_WIDTH))
        begin
            wx = WCMP_W'(MAX_WIDTH);
        end
        return COL_W'(wx - WCMP_W'(1));
    endfunction

    // Saturate a height to at least 3 and return the last row index
    function automatic logic [CFG_H_W-1:0] height_last(input logic [CFG_H_W-1:0] h);
        logic [CFG_H_W-1:0] hx;
        hx = (h < CFG_H_W'(3)) ? CFG_H_W'(3) : h;
        return hx - CFG_H_W'(1);
    endfunction

    // ------------------------------------------------------------------
    // Configuration: hold the last column and last row in use
    // ------------------------------------------------------------------
    logic [COL_W-1:0]   wlast_reg;
    logic [CFG_H_W-1:0] hlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg <= width_last(CFG_W_W'(RESET_WIDTH));
            hlast_reg <= height_last(CFG_H_W'(RESET_HEIGHT));
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                CFG_IMAGE_WIDTH:  wlast_reg <= width_last(cfg_wdata[CFG_W_W-1:0]);
                CFG_IMAGE_HEIGHT: hlast_reg <= height_last(cfg_wdata[CFG_H_W-1:0]);
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake chain: input stage -> window stage -> median unit
    // ------------------------------------------------------------------
    logic accept;
    logic rdy1;
    logic rdy2;
    logic adv1;
    logic med_ready;

    logic v1_reg;
    logic v2_reg;

    assign rdy2     = !v2_reg || med_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign accept   = s_tvalid && s_tready;
    assign adv1     = v1_reg && rdy2;

    // ------------------------------------------------------------------
    // Position of the accepted pixel and the next position
    // ------------------------------------------------------------------
    logic [CFG_H_W-1:0] row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [CFG_H_W-1:0] pos_row;
    logic [COL_W-1:0]   pos_col;
    logic [CFG_H_W-1:0] row_next;
    logic [COL_W-1:0]   col_next;
    logic [COL_W-1:0]   col_m1;
    logic               pos_emit;

    always_comb
    begin
        // frame start puts the position back to the top left
        pos_row = s_tuser ? '0 : row_reg;
        pos_col = s_tuser ? '0 : col_reg;
        if (pos_col >= wlast_reg)
        begin
            col_next = '0;
            row_next = (pos_row >= hlast_reg) ? '0 : pos_row + CFG_H_W'(1);
        end
        else
        begin
            col_next = pos_col + COL_W'(1);
            row_next = pos_row;
        end
        pos_emit = (pos_row >= CFG_H_W'(2)) && (pos_col >= COL_W'(2));
        col_m1   = pos_col - COL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ------------------------------------------------------------------
    // Input stage: hold the pixel and its tag while the line pair is read
    // ------------------------------------------------------------------
    pix_t             px1_reg;
    logic [COL_W-1:0] col1_reg;
    logic             emit1_reg;
    out_meta_t        meta1_reg;
    line_pair_t       rd_pair;
    line_pair_t       wr_pair;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (rdy1)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px1_reg        <= s_tdata[PIX_W-1:0];
            col1_reg       <= pos_col;
            emit1_reg      <= pos_emit;
            meta1_reg.row  <= pos_row - CFG_H_W'(1);
            meta1_reg.col  <= OUT_COL_W'(col_m1);
            meta1_reg.last <= (pos_row == hlast_reg) && (pos_col == wlast_reg);
        end
    end

    // Shift the column down the buffers: the previous row moves to upper
    assign wr_pair.upper = rd_pair.lower;
    assign wr_pair.lower = px1_reg;

    mf3_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (pos_col),
        .wr_en   (adv1),
        .wr_addr (col1_reg),
        .wr_data (wr_pair),
        .rd_data (rd_pair)
    );

    // ------------------------------------------------------------------
    // Window stage: every pixel shifts the window; only interior pixels
    // pass a request on to the median unit
    // ------------------------------------------------------------------
    window_t   win_reg;
    out_meta_t meta2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg  <= 1'b0;
            win_reg <= '0;
        end
        else
        begin
            if (rdy2)
            begin
                v2_reg <= v1_reg && emit1_reg;
            end
            if (adv1)
            begin
                for (int r = 0; r < WINDOW; r++)
                begin
                    for (int c = 0; c < WINDOW - 1; c++)
                    begin
                        win_reg[r*WINDOW+c] <= win_reg[r*WINDOW+c+1];
                    end
                end
                win_reg[WINDOW-1]           <= rd_pair.upper;
                win_reg[2*WINDOW-1]         <= rd_pair.lower;
                win_reg[WINDOW*WINDOW-1]    <= px1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            meta2_reg <= meta1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Median unit and output register
    // ------------------------------------------------------------------
    pix_t      out_median;
    out_meta_t out_meta;

    mf3_median u_median (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v2_reg),
        .in_ready   (med_ready),
        .win        (win_reg),
        .in_meta    (meta2_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_median (out_median),
        .out_meta   (out_meta)
    );

    assign m_tdata = {5'b0, out_meta.col, out_meta.row, out_median};
    assign m_tlast = out_meta.last;

endmodule
